// File: design/mpg_pkg.sv
package mpg_pkg;

  localparam int unsigned KibW = 48;
  localparam int unsigned ByteW = 58;
  localparam int unsigned KibShift = 10;
  localparam int unsigned InDataW = 440;
  localparam int unsigned OutDataW = 64;

  localparam logic [1:0] MODE_ACTIVE = 2'd0;
  localparam logic [1:0] MODE_PRESSURE = 2'd1;
  localparam logic [1:0] MODE_PAUSED = 2'd2;
  localparam logic [1:0] MODE_RECOVERY = 2'd3;

  typedef enum logic [3:0] {
    ST_ACTIVE = 4'b0001,
    ST_PRESSURE = 4'b0010,
    ST_PAUSED = 4'b0100,
    ST_RECOVERY = 4'b1000
  } state_e;

  typedef struct packed {
    logic manual_pause;
    logic has_reported_available;
    logic [KibW-1:0] reported_available_kib;
    logic [KibW-1:0] mem_total_kib;
    logic [KibW-1:0] mem_free_kib;
    logic [KibW-1:0] buffers_kib;
    logic [KibW-1:0] cached_kib;
    logic [KibW-1:0] reclaimable_kib;
    logic [KibW-1:0] shared_kib;
    logic [KibW-1:0] swap_total_kib;
    logic [KibW-1:0] swap_free_kib;
  } poll_t;

  typedef struct packed {
    logic [ByteW-1:0] avail_bytes;
    logic swap_low;
  } derived_t;

  typedef struct packed {
    logic [1:0] mode;
    logic accepting;
    logic critical;
  } decision_t;

  function automatic logic [1:0] state_code(state_e st);
    logic [1:0] code;
    case (st)
      ST_ACTIVE: code = MODE_ACTIVE;
      ST_PRESSURE: code = MODE_PRESSURE;
      ST_PAUSED: code = MODE_PAUSED;
      ST_RECOVERY: code = MODE_RECOVERY;
      default: code = MODE_ACTIVE;
    endcase
    return code;
  endfunction

endpackage

// File: design/memory_pressure_governor_core.sv
// memory pressure governor
// input stream: one poll transaction per accepted beat on s_axis. tdata carries the
// manual pause flag and nine 48-bit KiB counters, tuser flags a valid reported
// available figure. output stream: one result transaction per poll on m_axis with
// the new mode, the accepting flag, available memory in bytes and the critical flag.
// reserve_bytes is written through cfg_we_i / cfg_wdata_i; the user must write it
// only while no poll is in flight, as the block does not enforce this. a poll is
// taken into the input register, evaluated combinationally and its result registered
// in the result register. throughput: one poll per cycle while results are taken; the
// mode update between the two registers is the only loop, through the mode register.
// receiver stall: the result register holds; the input register still takes one more
// poll, then s_axis_tready drops until the result is taken.
// reset: mode active, recovery count zero, reserve zero, both stages empty.
module memory_pressure_governor_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mpg_pkg::ByteW-1:0]      cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // manual_pause, reported_available_kib, mem_total_kib, mem_free_kib, buffers_kib,
  // cached_kib, reclaimable_kib, shared_kib, swap_total_kib, swap_free_kib, zero fill
  input  logic [mpg_pkg::InDataW-1:0]    s_axis_tdata,
  // has_reported_available
  input  logic [0:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // mode, accepting, available_bytes, critical, zero fill
  output logic [mpg_pkg::OutDataW-1:0]   m_axis_tdata
);

  logic [mpg_pkg::ByteW-1:0] reserve_q;
  logic in_valid_q;
  mpg_pkg::poll_t poll_q, poll_d;
  logic out_valid_q;
  logic [mpg_pkg::OutDataW-1:0] out_data_q, out_data_d;
  logic out_adv;
  logic in_take;
  logic update;
  mpg_pkg::derived_t derived;
  mpg_pkg::decision_t decision;

  assign out_adv = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_adv;
  assign in_take = s_axis_tvalid && s_axis_tready;
  assign update = in_valid_q && out_adv;

  always_comb begin
    poll_d.manual_pause = s_axis_tdata[0];
    poll_d.has_reported_available = s_axis_tuser[0];
    poll_d.reported_available_kib = s_axis_tdata[1 +: mpg_pkg::KibW];
    poll_d.mem_total_kib = s_axis_tdata[1 + mpg_pkg::KibW +: mpg_pkg::KibW];
    poll_d.mem_free_kib = s_axis_tdata[1 + 2*mpg_pkg::KibW +: mpg_pkg::KibW];
    poll_d.buffers_kib = s_axis_tdata[1 + 3*mpg_pkg::KibW +: mpg_pkg::KibW];
    poll_d.cached_kib = s_axis_tdata[1 + 4*mpg_pkg::KibW +: mpg_pkg::KibW];
    poll_d.reclaimable_kib = s_axis_tdata[1 + 5*mpg_pkg::KibW +: mpg_pkg::KibW];
    poll_d.shared_kib = s_axis_tdata[1 + 6*mpg_pkg::KibW +: mpg_pkg::KibW];
    poll_d.swap_total_kib = s_axis_tdata[1 + 7*mpg_pkg::KibW +: mpg_pkg::KibW];
    poll_d.swap_free_kib = s_axis_tdata[1 + 8*mpg_pkg::KibW +: mpg_pkg::KibW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserve_q <= '0;
    end else if (cfg_we_i) begin
      reserve_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      poll_q <= poll_d;
    end
    if (update) begin
      out_data_q <= out_data_d;
    end
  end

  mpg_avail u_avail (
    .poll_i    (poll_q),
    .derived_o (derived)
  );

  mpg_mode u_mode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .update_i        (update),
    .manual_pause_i  (poll_q.manual_pause),
    .reserve_bytes_i (reserve_q),
    .derived_i       (derived),
    .decision_o      (decision)
  );

  assign out_data_d = {2'b00, decision.critical, derived.avail_bytes,
                       decision.accepting, decision.mode};

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;

endmodule

// File: design/mpg_avail.sv
module mpg_avail (
  input  mpg_pkg::poll_t    poll_i,
  output mpg_pkg::derived_t derived_o
);

  logic [mpg_pkg::KibW:0] cache_sum;
  logic [mpg_pkg::KibW:0] cache_net;
  logic [mpg_pkg::KibW+1:0] fall_sum;
  logic [mpg_pkg::KibW-1:0] fall_kib;
  logic [mpg_pkg::KibW-1:0] avail_kib;
  logic total_ok;
  logic [mpg_pkg::KibW+13:0] swf_scaled;
  logic [mpg_pkg::KibW+13:0] swt_scaled;

  assign total_ok = poll_i.mem_total_kib != '0;

  // free + buffers + max(cached + reclaimable - shared, 0)
  assign cache_sum = {1'b0, poll_i.cached_kib} + {1'b0, poll_i.reclaimable_kib};
  assign cache_net = (cache_sum > {1'b0, poll_i.shared_kib}) ?
                     cache_sum - {1'b0, poll_i.shared_kib} : '0;
  assign fall_sum = {2'b00, poll_i.mem_free_kib} + {2'b00, poll_i.buffers_kib}
                  + {1'b0, cache_net};
  assign fall_kib = (fall_sum > {2'b00, poll_i.mem_total_kib}) ?
                    poll_i.mem_total_kib : fall_sum[mpg_pkg::KibW-1:0];

  always_comb begin
    if (!total_ok) begin
      avail_kib = '0;
    end else if (poll_i.has_reported_available) begin
      avail_kib = poll_i.reported_available_kib;
    end else begin
      avail_kib = fall_kib;
    end
  end

  assign derived_o.avail_bytes = {avail_kib, {mpg_pkg::KibShift{1'b0}}};

  // free*1024 < floor(total*1024/20)  <=>  5120*free + 5 <= 256*total
  assign swf_scaled = {2'b00, poll_i.swap_free_kib, 12'd0}
                    + {4'b0000, poll_i.swap_free_kib, 10'd0} + 62'd5;
  assign swt_scaled = {6'd0, poll_i.swap_total_kib, 8'd0};

  assign derived_o.swap_low = total_ok && (poll_i.swap_total_kib != '0)
                            && (swf_scaled <= swt_scaled);

endmodule

// File: design/mpg_mode.sv
module mpg_mode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        update_i,
  input  logic                        manual_pause_i,
  input  logic [mpg_pkg::ByteW-1:0]   reserve_bytes_i,
  input  mpg_pkg::derived_t           derived_i,
  output mpg_pkg::decision_t          decision_o
);

  mpg_pkg::state_e state_q, state_d;
  logic [1:0] count_q, count_d;
  logic avail_nz;
  logic below_half;
  logic below_res;
  logic crit;
  logic [1:0] count_inc;

  assign avail_nz = derived_i.avail_bytes != '0;
  assign below_half = derived_i.avail_bytes < (reserve_bytes_i >> 1);
  assign below_res = derived_i.avail_bytes < reserve_bytes_i;
  assign crit = !manual_pause_i && ((avail_nz && below_half)
                                    || (derived_i.swap_low && below_res));
  assign count_inc = (count_q == 2'd3) ? 2'd3 : count_q + 2'd1;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    if (manual_pause_i || crit) begin
      state_d = mpg_pkg::ST_PAUSED;
      count_d = 2'd0;
    end else if (avail_nz && below_res) begin
      state_d = mpg_pkg::ST_PRESSURE;
      count_d = 2'd0;
    end else if (state_q != mpg_pkg::ST_ACTIVE) begin
      count_d = count_inc;
      state_d = (count_inc == 2'd3) ? mpg_pkg::ST_ACTIVE : mpg_pkg::ST_RECOVERY;
    end else begin
      state_d = mpg_pkg::ST_ACTIVE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpg_pkg::ST_ACTIVE;
      count_q <= 2'd0;
    end else if (update_i) begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  assign decision_o.mode = mpg_pkg::state_code(state_d);
  assign decision_o.accepting = state_d == mpg_pkg::ST_ACTIVE;
  assign decision_o.critical = crit;

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import mpg_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam logic [KibW-1:0] KibZero = '0;
  localparam logic [KibW-1:0] KibMax = '1;
  localparam logic [ByteW-1:0] ReserveMax = '1;

  typedef struct packed {
    logic [1:0] mode;
    logic accepting;
    logic [ByteW-1:0] avail_bytes;
    logic critical;
  } decision_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [ByteW-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  poll_t pending_polls[$];
  decision_t expected_decisions[$];
  poll_t offered;
  decision_t got, want;

  logic [ByteW-1:0] reserve_q = '0;
  logic [1:0] mode_now = MODE_ACTIVE;
  logic [1:0] recov_cnt = '0;

  int errors = 0;
  int cycles = 0;
  int gap_tx = 0;
  int calm_tx = 0;
  int stall_rx = 0;
  int calm_rx = 0;
  bit hold_arm = 1'b0;
  bit hold_done = 1'b0;

  memory_pressure_governor_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  function automatic decision_t predict_decision(poll_t p);
    decision_t d;
    logic [KibW+1:0] cache, avail_kib;
    logic [KibW-1:0] swt, swf;
    logic [ByteW-1:0] avail, swt_b, swf_b;
    logic crit;
    logic [1:0] nxt;
    swt = p.swap_total_kib;
    swf = p.swap_free_kib;
    if (p.has_reported_available) begin
      avail_kib = {2'b0, p.reported_available_kib};
    end else begin
      cache = {2'b0, p.cached_kib} + {2'b0, p.reclaimable_kib};
      cache = (cache > {2'b0, p.shared_kib}) ? cache - {2'b0, p.shared_kib} : '0;
      avail_kib = {2'b0, p.mem_free_kib} + {2'b0, p.buffers_kib} + cache;
      if (p.mem_total_kib != '0 && avail_kib > {2'b0, p.mem_total_kib}) begin
        avail_kib = {2'b0, p.mem_total_kib};
      end
    end
    if (p.mem_total_kib == '0) begin
      avail_kib = '0;
      swt = '0;
      swf = '0;
    end
    avail = {avail_kib[KibW-1:0], 10'b0};
    swt_b = {swt, 10'b0};
    swf_b = {swf, 10'b0};
    crit = 1'b0;
    if (p.manual_pause) begin
      nxt = MODE_PAUSED;
      recov_cnt = '0;
    end else begin
      crit = (avail != '0 && avail < reserve_q / 58'd2) ||
             (swt_b != '0 && swf_b < swt_b / 58'd20 && avail < reserve_q);
      if (crit) begin
        nxt = MODE_PAUSED;
        recov_cnt = '0;
      end else if (avail != '0 && avail < reserve_q) begin
        nxt = MODE_PRESSURE;
        recov_cnt = '0;
      end else if (mode_now != MODE_ACTIVE) begin
        if (recov_cnt < 2'd3) recov_cnt = recov_cnt + 2'd1;
        nxt = (recov_cnt >= 2'd3) ? MODE_ACTIVE : MODE_RECOVERY;
      end else begin
        nxt = MODE_ACTIVE;
      end
    end
    mode_now = nxt;
    d.mode = nxt;
    d.accepting = (nxt == MODE_ACTIVE);
    d.avail_bytes = avail;
    d.critical = crit;
    return d;
  endfunction

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [KibW-1:0] rnd_kib(int bits);
    logic [63:0] r;
    logic [KibW-1:0] m;
    r = {$urandom, $urandom};
    m = (48'd1 << bits) - 48'd1;
    return r[KibW-1:0] & m;
  endfunction

  // mostly plausible polls scaled to mag bits, some pure noise
  function automatic poll_t rand_poll(int mag);
    poll_t p;
    bit noise;
    noise = ($urandom_range(0, 99) < 15);
    if (noise) mag = 48;
    p.manual_pause = noise ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 99) < 8);
    p.has_reported_available = noise ? ($urandom_range(0, 1) == 1)
                                     : ($urandom_range(0, 99) < 30);
    p.reported_available_kib = rnd_kib(mag);
    p.mem_total_kib = ($urandom_range(0, 99) < 5) ? KibZero : rnd_kib(mag);
    p.mem_free_kib = rnd_kib(mag);
    p.buffers_kib = rnd_kib(mag);
    p.cached_kib = rnd_kib(mag);
    p.reclaimable_kib = rnd_kib(mag);
    p.shared_kib = rnd_kib(mag);
    p.swap_total_kib = ($urandom_range(0, 3) == 0) ? KibZero : rnd_kib(mag);
    if (!noise && $urandom_range(0, 1) == 1) begin
      p.swap_free_kib = p.swap_total_kib / (19 + $urandom_range(0, 3));
    end else begin
      p.swap_free_kib = rnd_kib(mag);
    end
    return p;
  endfunction

  task automatic wait_idle();
    while (pending_polls.size() != 0 || s_axis_tvalid || expected_decisions.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reserve(logic [ByteW-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    reserve_q = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_decisions.push_back(predict_decision(offered));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_tx > 0) begin
          gap_tx--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_polls.size() != 0) begin
          offered = pending_polls.pop_front();
          s_axis_tdata <= {{(InDataW - 1 - 9 * KibW){1'b0}},
                           offered.swap_free_kib, offered.swap_total_kib, offered.shared_kib,
                           offered.reclaimable_kib, offered.cached_kib, offered.buffers_kib,
                           offered.mem_free_kib, offered.mem_total_kib,
                           offered.reported_available_kib, offered.manual_pause};
          s_axis_tuser <= offered.has_reported_available;
          s_axis_tvalid <= 1'b1;
          gap_tx = pick_gap(calm_tx);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_arm && !hold_done) begin
      hold_done = 1'b1;
      stall_rx = 300;
      m_axis_tready <= 1'b0;
    end else if (stall_rx > 0) begin
      stall_rx--;
      m_axis_tready <= 1'b0;
    end else begin
      stall_rx = pick_gap(calm_rx);
      m_axis_tready <= (stall_rx == 0);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.mode = m_axis_tdata[1:0];
      got.accepting = m_axis_tdata[2];
      got.avail_bytes = m_axis_tdata[3 +: ByteW];
      got.critical = m_axis_tdata[3 + ByteW];
      if (expected_decisions.size() == 0) begin
        $display("%0t: result transaction with none expected, got %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = expected_decisions.pop_front();
        if (got.mode != want.mode) begin
          $display("%0t: mode expected %0d got %0d", $time, want.mode, got.mode);
          errors++;
        end
        if (got.accepting != want.accepting) begin
          $display("%0t: accepting expected %0d got %0d", $time, want.accepting, got.accepting);
          errors++;
        end
        if (got.avail_bytes != want.avail_bytes) begin
          $display("%0t: available_bytes expected %h got %h", $time, want.avail_bytes,
                   got.avail_bytes);
          errors++;
        end
        if (got.critical != want.critical) begin
          $display("%0t: critical expected %0d got %0d", $time, want.critical, got.critical);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("memory_pressure_governor_core regression: fail");
      $finish;
    end
  end

  initial begin
    logic [63:0] r;
    logic [ByteW-1:0] rsv;
    int mag;
    int bits;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reserve at its reset value of zero
    pending_polls.push_back(poll_t'{1'b0, 1'b0, KibZero, KibZero, KibZero, KibZero,
                                    KibZero, KibZero, KibZero, KibZero, KibZero});
    pending_polls.push_back(poll_t'{1'b1, 1'b1, KibMax, KibMax, KibMax, KibMax,
                                    KibMax, KibMax, KibMax, KibMax, KibMax});
    // fallback sum wider than 48 bits, clamped to total
    pending_polls.push_back(poll_t'{1'b0, 1'b0, KibMax, KibMax, KibMax, KibMax,
                                    KibMax, KibMax, KibZero, KibMax, KibMax});
    // shared exceeds cache
    pending_polls.push_back(poll_t'{1'b0, 1'b0, KibZero, KibMax, 48'd100, 48'd200,
                                    48'd50, 48'd10, 48'd1000, KibZero, KibZero});
    // zero total
    pending_polls.push_back(poll_t'{1'b0, 1'b1, KibMax, KibZero, KibMax, KibMax,
                                    KibMax, KibMax, KibZero, KibMax, KibZero});
    wait_idle();
    write_reserve(ReserveMax);
    // manual pause while critical conditions hold
    pending_polls.push_back(poll_t'{1'b1, 1'b1, 48'd1, KibMax, KibZero, KibZero,
                                    KibZero, KibZero, KibZero, 48'd1000, KibZero});
    pending_polls.push_back(poll_t'{1'b0, 1'b1, 48'd1, KibMax, KibZero, KibZero,
                                    KibZero, KibZero, KibZero, KibZero, KibZero});
    pending_polls.push_back(poll_t'{1'b0, 1'b1, 48'h8000_0000_0005, KibMax, KibZero,
                                    KibZero, KibZero, KibZero, KibZero, 48'd1000, 48'd49});
    pending_polls.push_back(poll_t'{1'b0, 1'b1, 48'h8000_0000_0005, KibMax, KibZero,
                                    KibZero, KibZero, KibZero, KibZero, 48'd1000, 48'd50});
    pending_polls.push_back(poll_t'{1'b0, 1'b1, KibZero, KibMax, KibZero, KibZero,
                                    KibZero, KibZero, KibZero, KibZero, KibZero});
    pending_polls.push_back(poll_t'{1'b0, 1'b1, KibZero, KibMax, KibZero, KibZero,
                                    KibZero, KibZero, KibZero, 48'd1000, KibZero});
    pending_polls.push_back(poll_t'{1'b0, 1'b1, 48'd5, KibZero, KibZero, KibZero,
                                    KibZero, KibZero, KibZero, 48'd1000, KibZero});
    pending_polls.push_back(poll_t'{1'b0, 1'b1, KibMax, KibMax, KibZero, KibZero,
                                    KibZero, KibZero, KibZero, KibZero, KibZero});
    repeat (4) begin
      pending_polls.push_back(poll_t'{1'b0, 1'b0, KibZero, KibZero, KibMax, KibMax,
                                      KibZero, KibZero, KibZero, KibZero, KibZero});
    end
    wait_idle();
    write_reserve(58'd2048);
    pending_polls.push_back(poll_t'{1'b0, 1'b1, 48'd1, KibMax, KibZero, KibZero,
                                    KibZero, KibZero, KibZero, KibZero, KibZero});
    pending_polls.push_back(poll_t'{1'b0, 1'b1, 48'd2, KibMax, KibZero, KibZero,
                                    KibZero, KibZero, KibZero, KibZero, KibZero});
    pending_polls.push_back(poll_t'{1'b0, 1'b0, KibZero, 48'd3, 48'd1, KibZero,
                                    48'd1, KibZero, KibZero, KibZero, KibZero});

    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      if (ph == 0) begin
        mag = 48;
        rsv = ReserveMax;
      end else if (ph == 1) begin
        mag = $urandom_range(30, 48);
        rsv = '0;
      end else begin
        mag = $urandom_range(4, 47);
        bits = (mag + 11 > 58) ? 58 : mag + 11;
        r = {$urandom, $urandom};
        rsv = r[ByteW-1:0] & ((58'd1 << bits) - 58'd1);
      end
      write_reserve(rsv);
      if (ph == 2) hold_arm = 1'b1;
      repeat (100) pending_polls.push_back(rand_poll(mag));
    end

    wait_idle();
    if (errors == 0) begin
      $display("memory_pressure_governor_core regression: pass");
    end else begin
      $display("memory_pressure_governor_core regression: fail");
    end
    $finish;
  end

endmodule
